@@ src/rcnt_pkg.sv @@
// ----------------------------------------------------------------------------
// rcnt_pkg
// Shared types and constants for the replay-checked neighbour table.
// ----------------------------------------------------------------------------
`default_nettype none

package rcnt_pkg;

  localparam int unsigned TableDepth = 8;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned SlotW      = 3;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StReplay  = 2'd1,
    StNoSpace = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] source_node;
    logic [31:0] adv_cluster;
    logic [31:0] adv_term;
    logic [31:0] adv_nonce;
    logic [15:0] adv_score;
    logic [7:0]  adv_capacity;
    logic [31:0] adv_lease;
    logic [2:0]  adv_role;
    logic [31:0] time_now;
  } adv_in_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic [31:0]      stale_count;
  } adv_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic decide;
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ src/replay_checked_neighbor_table.sv @@
// ----------------------------------------------------------------------------
// replay_checked_neighbor_table
// Neighbour table of advertising heads with expiry and replay rejection.
// ----------------------------------------------------------------------------
// The input channel carries one head advertisement with the current time;
// the output channel returns status, slot and the stale counter for it.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low.
// One advertisement is handled at a time. After acceptance the entry match
// and slot claim are registered in the match state; in the decide state the
// replay check is made and the entry and the result register are written.
// The result is then presented until the receiver takes it. The sequencer in
// the controller walks accept, match, decide and hand over in turn, and the
// input stays stalled from acceptance until hand-over.
// While the receiver stalls, the result register holds its value and the
// input stays stalled. Reset clears all entry valid bits and the stale
// counter at once; the block can take a transaction in the first cycle
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module replay_checked_neighbor_table (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rcnt_pkg::adv_in_t  in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rcnt_pkg::adv_res_t      out_o
);
  import rcnt_pkg::*;

  dp_cmd_t cmd;

  rcnt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rcnt_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  // A result is only ever pending while the input side is held off.
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result pending while input open");

  // Every accepted transaction leads to a valid result after the match and decide states.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> ##3 out_valid_o)
    else $error("result not presented on time");

  // A full table reports slot zero.
  a_no_space_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.status == StNoSpace)) |-> (out_o.slot == '0))
    else $error("no-space result with nonzero slot");

  // The stale counter only moves on a replay.
  a_stale_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_o) && $past(out_valid_o, 5) && (out_o.status == StOk))
      |-> (out_o.stale_count == $past(out_o.stale_count)))
    else $error("stale counter changed without a replay");

endmodule

`default_nettype wire

@@ src/rcnt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcnt_ctrl
// Sequencer: accept, match, decide and hand over one transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module rcnt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rcnt_pkg::dp_cmd_t     cmd_o
);
  import rcnt_pkg::*;

  typedef enum logic [1:0] {
    SIdle,
    SMatch,
    SDecide,
    SDone
  } state_e;

  state_e state_q;
  logic   in_stall_q;
  logic   out_valid_q;
  logic   accept;

  assign accept      = in_valid_i && !in_stall_q;
  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.match  = (state_q == SMatch);
    cmd_o.decide = (state_q == SDecide);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            state_q    <= SMatch;
            in_stall_q <= 1'b1;
          end
        end
        SMatch: begin
          state_q <= SDecide;
        end
        SDecide: begin
          state_q     <= SDone;
          out_valid_q <= 1'b1;
        end
        SDone: begin
          if (!out_stall_i) begin
            state_q     <= SIdle;
            out_valid_q <= 1'b0;
            in_stall_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/rcnt_datapath.sv @@
// ----------------------------------------------------------------------------
// rcnt_datapath
// Neighbour entries, parallel node match, slot claim, replay check and update.
// ----------------------------------------------------------------------------
`default_nettype none

module rcnt_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rcnt_pkg::dp_cmd_t  cmd_i,
  input  wire rcnt_pkg::adv_in_t  in_i,
  output rcnt_pkg::adv_res_t      out_o
);
  import rcnt_pkg::*;

  // Entry storage.
  logic [TableDepth-1:0] valid_q;
  logic [15:0]           node_q     [TableDepth];
  logic [31:0]           cluster_q  [TableDepth];
  logic [31:0]           term_q     [TableDepth];
  logic [15:0]           score_q    [TableDepth];
  logic [7:0]            capacity_q [TableDepth];
  logic [31:0]           expiry_q   [TableDepth];
  logic [31:0]           nonce_q    [TableDepth];
  logic [2:0]            role_q     [TableDepth];
  logic [31:0]           stale_q, stale_d;

  adv_in_t               in_q;
  adv_res_t              out_q;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  found_q, claim_q;

  logic [TableDepth-1:0] hit_vec, free_vec;
  logic [IdxW-1:0]       hit_idx, free_idx;
  logic [31:0]           diff [TableDepth];
  logic                  replay;
  logic                  do_write;

  // Parallel lookup of the node id and of free or expired slots.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TableDepth; i++) begin
      diff[i]     = in_q.time_now - expiry_q[i];
      hit_vec[i]  = valid_q[i] && (node_q[i] == in_q.source_node);
      free_vec[i] = !valid_q[i] || !diff[i][31];
    end
    // Scan downwards so that the lowest index wins.
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IdxW'(i);
      end
      if (free_vec[i]) begin
        free_idx = IdxW'(i);
      end
    end
    idx_d = (|hit_vec) ? hit_idx : free_idx;
  end

  // A claimed slot is never a replay, and neither is an entry whose last nonce is zero.
  assign replay = found_q && !claim_q && (nonce_q[idx_q] != 32'd0) &&
                  (cluster_q[idx_q] == in_q.adv_cluster) &&
                  (term_q[idx_q] == in_q.adv_term) &&
                  (in_q.adv_nonce <= nonce_q[idx_q]);

  assign do_write = cmd_i.decide && found_q && !replay;

  always_comb begin
    stale_d = stale_q;
    if (replay && (stale_q != '1)) begin
      stale_d = stale_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      stale_q <= '0;
    end else begin
      if (do_write) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (cmd_i.decide) begin
        stale_q <= stale_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.match) begin
      idx_q   <= idx_d;
      found_q <= (|hit_vec) || (|free_vec);
      claim_q <= !(|hit_vec) && (|free_vec);
    end
    if (do_write) begin
      node_q[idx_q]     <= in_q.source_node;
      cluster_q[idx_q]  <= in_q.adv_cluster;
      term_q[idx_q]     <= in_q.adv_term;
      score_q[idx_q]    <= in_q.adv_score;
      capacity_q[idx_q] <= in_q.adv_capacity;
      expiry_q[idx_q]   <= in_q.time_now + in_q.adv_lease;
      nonce_q[idx_q]    <= in_q.adv_nonce;
      role_q[idx_q]     <= in_q.adv_role;
    end
    if (cmd_i.decide) begin
      out_q.stale_count <= stale_d;
      if (!found_q) begin
        out_q.status <= StNoSpace;
        out_q.slot   <= '0;
      end else begin
        out_q.status <= replay ? StReplay : StOk;
        out_q.slot   <= SlotW'(idx_q);
      end
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the replay-checked neighbour table.
// ----------------------------------------------------------------------------
// Head advertisements go in over the valid/stall input channel. Each accepted
// transaction is fed to a scoreboard that keeps its own copy of the table and
// the stale counter and queues the status, slot and counter it expects. Every
// result is checked against the oldest entry in that queue. A short directed
// sequence covers the edge cases: empty and all-ones fields, replays, a full
// table, expiry and lookup of an expired entry. Random traffic then follows
// in four phases that vary sender gaps and receiver stalls. The random traffic
// models a set of heads that send ordered nonces, with replays, term and
// cluster changes and foreign nodes mixed in.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcnt_pkg::*;

  localparam int NodePool = 12;
  localparam int PhaseItems = 475;

  class neighbor_scoreboard;
    bit          live [TableDepth];
    bit [15:0]   node_id [TableDepth];
    bit [31:0]   cluster [TableDepth];
    bit [31:0]   term [TableDepth];
    bit [15:0]   score [TableDepth];
    bit [7:0]    capacity [TableDepth];
    bit [31:0]   deadline [TableDepth];
    bit [31:0]   seen_nonce [TableDepth];
    bit [2:0]    role [TableDepth];
    bit [31:0]   stale;
    adv_res_t    owed_q [$];
    int          fails;
    int          n_ok;
    int          n_replay;
    int          n_full;

    function new();
      for (int i = 0; i < TableDepth; i++) live[i] = 1'b0;
      stale = '0;
      fails = 0;
      n_ok = 0;
      n_replay = 0;
      n_full = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Works out the outcome of one accepted advertisement.
    function void note_advert(adv_in_t a);
      int       hit;
      bit       found;
      bit [31:0] since;
      adv_res_t r;
      hit = 0;
      found = 1'b0;
      for (int i = 0; i < TableDepth; i++) begin
        if (!found && live[i] && node_id[i] == a.source_node) begin
          hit = i;
          found = 1'b1;
        end
      end
      // A slot is claimable when free or when its deadline has been reached.
      for (int i = 0; i < TableDepth; i++) begin
        since = a.time_now - deadline[i];
        if (!found && (!live[i] || !since[31])) begin
          live[i] = 1'b1;
          node_id[i] = a.source_node;
          cluster[i] = '0;
          term[i] = '0;
          score[i] = '0;
          capacity[i] = '0;
          deadline[i] = '0;
          seen_nonce[i] = '0;
          role[i] = '0;
          hit = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = StNoSpace;
        hit = 0;
        n_full++;
      end else if (seen_nonce[hit] != 0 && cluster[hit] == a.adv_cluster &&
                   term[hit] == a.adv_term && a.adv_nonce <= seen_nonce[hit]) begin
        r.status = StReplay;
        if (stale != 32'hFFFF_FFFF) stale++;
        n_replay++;
      end else begin
        r.status = StOk;
        cluster[hit] = a.adv_cluster;
        term[hit] = a.adv_term;
        score[hit] = a.adv_score;
        capacity[hit] = a.adv_capacity;
        deadline[hit] = a.time_now + a.adv_lease;
        seen_nonce[hit] = a.adv_nonce;
        role[hit] = a.adv_role;
        n_ok++;
      end
      r.slot = 3'(hit);
      r.stale_count = stale;
      owed_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_result(adv_res_t got);
      adv_res_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result arrived with nothing outstanding (status %0d)",
                         got.status));
      end else begin
        want = owed_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d, wanted %0d", got.status, want.status));
        if (got.slot !== want.slot)
          report($sformatf("slot got %0d, wanted %0d", got.slot, want.slot));
        if (got.stale_count !== want.stale_count)
          report($sformatf("stale count got %0d, wanted %0d",
                           got.stale_count, want.stale_count));
      end
    endtask
  endclass

  logic     clk_i = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  adv_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  adv_res_t out_data;

  int       idle_pct = 0;
  int       stall_pct = 0;
  int       hold_left = 0;

  bit [15:0] pool_node [NodePool];
  bit [31:0] gen_cluster [NodePool];
  bit [31:0] gen_term [NodePool];
  bit [31:0] gen_nonce [NodePool];
  bit [31:0] clock_ms;

  neighbor_scoreboard sb = new();

  replay_checked_neighbor_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, or an unbroken hold-off while hold_left runs down.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Called and returning at a falling edge.
  task send_item(adv_in_t a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= a;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_advert(a);
    @(negedge clk_i);
  endtask

  task drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic adv_in_t mk(bit [15:0] node, bit [31:0] clu, bit [31:0] trm,
                                 bit [31:0] nonce, bit [31:0] lease, bit [31:0] now,
                                 bit [15:0] scr, bit [7:0] cap, bit [2:0] rl);
    adv_in_t a;
    a.source_node = node;
    a.adv_cluster = clu;
    a.adv_term = trm;
    a.adv_nonce = nonce;
    a.adv_score = scr;
    a.adv_capacity = cap;
    a.adv_lease = lease;
    a.adv_role = rl;
    a.time_now = now;
    return a;
  endfunction

  // Mostly ordered advertisements from a fixed set of heads, some replays,
  // some term or cluster changes, and a share of foreign or garbled traffic.
  function automatic adv_in_t random_adv();
    adv_in_t     a;
    int          k;
    int unsigned kind;
    int unsigned lr;
    a.adv_score = 16'($urandom);
    a.adv_capacity = 8'($urandom);
    a.adv_role = 3'($urandom);
    clock_ms += $urandom_range(40);
    if ($urandom_range(99) < 2) clock_ms = $urandom();
    a.time_now = clock_ms;
    kind = $urandom_range(99);
    if ($urandom_range(99) < 88) begin
      k = $urandom_range(NodePool - 1);
      a.source_node = pool_node[k];
      if (kind < 55) begin
        gen_nonce[k] += 1 + $urandom_range(5);
      end else if (kind >= 72 && kind < 82) begin
        gen_term[k] += 1;
        gen_nonce[k] = $urandom_range(3);
      end else if (kind >= 82 && kind < 90) begin
        gen_cluster[k] = $urandom();
        gen_nonce[k] = 1 + $urandom_range(3);
      end
      a.adv_cluster = gen_cluster[k];
      a.adv_term = gen_term[k];
      a.adv_nonce = gen_nonce[k];
      // Replays repeat or undercut the last nonce sent.
      if (kind >= 55 && kind < 72) a.adv_nonce = gen_nonce[k] - $urandom_range(2);
      if (kind >= 90) begin
        a.adv_cluster = $urandom();
        a.adv_term = $urandom();
        a.adv_nonce = $urandom();
      end
    end else begin
      a.source_node = 16'($urandom);
      a.adv_cluster = $urandom();
      a.adv_term = $urandom();
      a.adv_nonce = $urandom();
    end
    lr = $urandom_range(99);
    if (lr < 65)      a.adv_lease = $urandom_range(600);
    else if (lr < 82) a.adv_lease = $urandom_range(6000);
    else if (lr < 90) a.adv_lease = '0;
    else if (lr < 95) a.adv_lease = $urandom();
    else begin
      case ($urandom_range(2))
        0:       a.adv_lease = 32'h7FFF_FFFF;
        1:       a.adv_lease = 32'h8000_0000;
        default: a.adv_lease = 32'hFFFF_FFFF;
      endcase
    end
    return a;
  endfunction

  task run_phase(int idle, int stall, bit long_hold);
    drain();
    @(posedge clk_i);
    idle_pct = idle;
    stall_pct = stall;
    if (long_hold) hold_left = 300;
    @(negedge clk_i);
    repeat (PhaseItems) send_item(random_adv());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    for (int i = 0; i < NodePool; i++) begin
      pool_node[i] = {12'($urandom), 4'(i)};
      gen_cluster[i] = $urandom();
      gen_term[i] = $urandom();
      gen_nonce[i] = '0;
    end
    clock_ms = $urandom();
    repeat (4) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // All-zero advertisement, then a zero nonce again, which is never a replay.
    send_item(mk('0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_item(mk('0, '0, '0, '0, 32'd1000, 32'd100, 16'h1, 8'h1, 3'h1));
    // All-ones fields; the deadline wraps past zero.
    send_item(mk('1, '1, '1, '1, '1, 32'd200, '1, '1, '1));
    send_item(mk('1, '1, '1, '1, 32'd50, 32'd200, 16'h2, 8'h2, 3'h2));
    send_item(mk('1, '1, '1, 32'd5, 32'd50, 32'd205, 16'h3, 8'h3, 3'h3));
    send_item(mk('1, '1, '0, 32'd5, 32'd10000, 32'd210, 16'h4, 8'h4, 3'h4));
    send_item(mk('1, '0, '0, 32'd3, 32'd10000, 32'd220, 16'h5, 8'h5, 3'h5));
    // Fill the remaining slots, then a newcomer finds no room.
    for (int n = 1; n <= 6; n++)
      send_item(mk(16'(n), 32'hC0, 32'h1, 32'd10, 32'd10000, 32'd300, 16'(n), 8'(n), 3'(n)));
    send_item(mk(16'd7, 32'hC0, 32'h1, 32'd9, '0, 32'd300, '0, '0, 3'h6));
    // Exactly at the deadline the slot counts as expired and is taken over.
    send_item(mk(16'd7, 32'hC0, 32'h1, 32'd9, '0, 32'd1100, '0, '0, 3'h6));
    send_item(mk(16'd7, 32'hC0, 32'h1, 32'd9, '0, 32'd1100, '0, '0, 3'h6));
    send_item(mk('0, '0, '0, '0, 32'h7FFF_FFFF, 32'd1200, '0, '0, '0));
    // Lookup still finds an expired entry, so this stays a replay.
    send_item(mk(16'd1, 32'hC0, 32'h1, 32'd4, 32'd5, 32'd20000, '0, '0, '0));
    send_item(mk(16'h1234, 32'd5, 32'd5, 32'd5, 32'h8000_0000, 32'd20000, '0, '0, '0));
    send_item(mk(16'h1235, 32'd5, 32'd5, 32'd5, 32'h8000_0000, 32'd20000, '0, '0, '0));

    run_phase(0, 0, 1'b1);
    run_phase(67, 0, 1'b0);
    run_phase(0, 67, 1'b0);
    run_phase(16, 16, 1'b0);

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("Sent %0d advertisements: %0d stored, %0d rejected as replays,",
             sb.n_ok + sb.n_replay + sb.n_full, sb.n_ok, sb.n_replay);
    $display("%0d refused for a full table; traffic ran without gaps,", sb.n_full);
    $display("with sender gaps, with receiver stalls, both, and one long hold-off.");
    if (sb.fails == 0) begin
      $display("PASS replay_checked_neighbor_table");
    end else begin
      $display("FAIL replay_checked_neighbor_table");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL replay_checked_neighbor_table");
    $finish;
  end

endmodule

@@ sim.f @@
src/rcnt_pkg.sv
src/rcnt_ctrl.sv
src/rcnt_datapath.sv
src/replay_checked_neighbor_table.sv
sim/tb_top.sv
